### rtl/sltd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sltd_pkg
// shared types and constants for the sync/length/trailer deframer
// ----------------------------------------------------------------------------
package sltd_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_SYNC_BYTE      = 2'd0;
   localparam logic [1:0] CSR_TRAILER_FIRST  = 2'd1;
   localparam logic [1:0] CSR_TRAILER_SECOND = 2'd2;
   localparam logic [1:0] CSR_TRAILER_THIRD  = 2'd3;

   // reset values of the configuration registers
   localparam logic [7:0] SYNC_BYTE_RST      = 8'd133;
   localparam logic [7:0] TRAILER_FIRST_RST  = 8'd169;
   localparam logic [7:0] TRAILER_SECOND_RST = 8'd22;
   localparam logic [7:0] TRAILER_THIRD_RST  = 8'd243;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_ACCEPTED = 2'd1;
   localparam logic [1:0] KIND_DROPPED  = 2'd2;
   localparam logic [1:0] KIND_ABANDON  = 2'd3;

   // parser phases
   localparam logic [3:0] PH_SYNC0  = 4'd0;
   localparam logic [3:0] PH_SYNC1  = 4'd1;
   localparam logic [3:0] PH_SYNC2  = 4'd2;
   localparam logic [3:0] PH_TYPE   = 4'd3;
   localparam logic [3:0] PH_ID     = 4'd4;
   localparam logic [3:0] PH_LEN_HI = 4'd5;
   localparam logic [3:0] PH_LEN_LO = 4'd6;
   localparam logic [3:0] PH_BODY   = 4'd7;
   localparam logic [3:0] PH_TR1    = 4'd8;
   localparam logic [3:0] PH_TR2    = 4'd9;

   typedef struct packed {
      logic [7:0] sync_byte;
      logic [7:0] trailer_first;
      logic [7:0] trailer_second;
      logic [7:0] trailer_third;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [7:0]  frame_type;
      logic [7:0]  message_id;
      logic [15:0] payload_length;
   } result_type;

endpackage

### rtl/sync_length_trailer_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_trailer_deframer
// recovers sync / length / trailer framed messages from a byte stream
//
//   channel  direction  handshake             payload
//   req      in         req_valid, req_stall  req_rx_byte
//   rsp      out        rsp_valid, rsp_stall  rsp_kind .. rsp_payload_length
//   csr      in         csr_write_en          csr_index, csr_wdata
//
// one byte per cycle unless req_stall; each result is registered in the queue
// parser state updates on each byte taken, from a small phase machine
// reset clears parser state, queue and registers to their defaults
// a two-entry output queue absorbs one more result while rsp is stalled;
// req_stall rises only when both entries hold results
// ----------------------------------------------------------------------------
module sync_length_trailer_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_byte_index,
   output logic [7:0]  rsp_frame_type,
   output logic [7:0]  rsp_message_id,
   output logic [15:0] rsp_payload_length,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import sltd_pkg::*;

   cfg_type    cfg_ff;
   logic       byte_take;
   logic       res_valid;
   result_type res;
   logic       q_full;
   result_type head_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte      <= SYNC_BYTE_RST;
         cfg_ff.trailer_first  <= TRAILER_FIRST_RST;
         cfg_ff.trailer_second <= TRAILER_SECOND_RST;
         cfg_ff.trailer_third  <= TRAILER_THIRD_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SYNC_BYTE:      cfg_ff.sync_byte      <= csr_wdata;
            CSR_TRAILER_FIRST:  cfg_ff.trailer_first  <= csr_wdata;
            CSR_TRAILER_SECOND: cfg_ff.trailer_second <= csr_wdata;
            CSR_TRAILER_THIRD:  cfg_ff.trailer_third  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_stall = q_full;
   assign byte_take = req_valid && !q_full;

   sltd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .byte_take (byte_take),
      .rx_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   sltd_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (byte_take && res_valid),
      .push_res   (res),
      .full       (q_full),
      .head_valid (rsp_valid),
      .head_res   (head_res),
      .pop        (rsp_valid && !rsp_stall)
   );

   assign rsp_kind           = head_res.kind;
   assign rsp_data_byte      = head_res.data_byte;
   assign rsp_byte_index     = head_res.byte_index;
   assign rsp_frame_type     = head_res.frame_type;
   assign rsp_message_id     = head_res.message_id;
   assign rsp_payload_length = head_res.payload_length;

endmodule

### rtl/sltd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sltd_core
// frame parser state and per-byte next-state / result logic
// ----------------------------------------------------------------------------
module sltd_core (
   input  logic                clock,
   input  logic                reset,
   input  sltd_pkg::cfg_type   cfg,
   input  logic                byte_take,
   input  logic [7:0]          rx_byte,
   output logic                res_valid,
   output sltd_pkg::result_type res
);
   import sltd_pkg::*;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  held_type_ff, held_type_in;
   logic [7:0]  held_id_ff, held_id_in;
   logic [15:0] decl_len_ff, decl_len_in;
   logic [15:0] rcv_cnt_ff, rcv_cnt_in;

   always_comb begin
      logic [3:0] body_phase;
      logic       advanced;
      logic       finished;
      body_phase   = PH_BODY;
      advanced     = 1'b0;
      finished     = 1'b0;
      phase_in     = phase_ff;
      held_type_in = held_type_ff;
      held_id_in   = held_id_ff;
      decl_len_in  = decl_len_ff;
      rcv_cnt_in   = rcv_cnt_ff;
      res_valid    = 1'b0;
      res.kind           = KIND_PAYLOAD;
      res.data_byte      = 8'd0;
      res.byte_index     = rcv_cnt_ff;
      res.frame_type     = held_type_ff;
      res.message_id     = held_id_ff;
      res.payload_length = decl_len_ff;
      case (phase_ff)
         PH_SYNC1, PH_SYNC2: begin
            if (rx_byte == cfg.sync_byte) begin
               phase_in = phase_ff + 4'd1;
            end
         end
         PH_TYPE: begin
            held_type_in = rx_byte;
            phase_in     = PH_ID;
         end
         PH_ID: begin
            held_id_in = rx_byte;
            phase_in   = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            decl_len_in = {rx_byte, 8'd0};
            phase_in    = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            decl_len_in = {decl_len_ff[15:8], rx_byte};
            rcv_cnt_in  = 16'd0;
            phase_in    = PH_BODY;
         end
         PH_BODY, PH_TR1, PH_TR2: begin
            if (phase_ff == PH_BODY && rx_byte == cfg.trailer_first) begin
               body_phase = PH_TR1;
               advanced   = 1'b1;
            end else if (phase_ff == PH_TR1) begin
               if (rx_byte == cfg.trailer_second) begin
                  body_phase = PH_TR2;
                  advanced   = 1'b1;
               end
            end else if (phase_ff == PH_TR2) begin
               finished = (rx_byte == cfg.trailer_third);
            end
            if (finished) begin
               res_valid  = 1'b1;
               res.kind   = (rcv_cnt_ff == decl_len_ff) ? KIND_ACCEPTED : KIND_DROPPED;
               phase_in   = PH_SYNC0;
               rcv_cnt_in = 16'd0;
            end else if (rcv_cnt_ff < decl_len_ff) begin
               res_valid     = 1'b1;
               res.data_byte = rx_byte;
               rcv_cnt_in    = rcv_cnt_ff + 16'd1;
               phase_in      = body_phase;
            end else if (!advanced) begin
               res_valid  = 1'b1;
               res.kind   = KIND_ABANDON;
               phase_in   = PH_SYNC0;
               rcv_cnt_in = 16'd0;
            end else begin
               phase_in = body_phase;
            end
         end
         default: begin
            // sync hunt from zero, unused codes included
            phase_in = (rx_byte == cfg.sync_byte) ? PH_SYNC1 : PH_SYNC0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC0;
         held_type_ff <= 8'd0;
         held_id_ff   <= 8'd0;
         decl_len_ff  <= 16'd0;
         rcv_cnt_ff   <= 16'd0;
      end else if (byte_take) begin
         phase_ff     <= phase_in;
         held_type_ff <= held_type_in;
         held_id_ff   <= held_id_in;
         decl_len_ff  <= decl_len_in;
         rcv_cnt_ff   <= rcv_cnt_in;
      end
   end

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_TR2)
      else $error("parser phase out of range");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rcv_cnt_ff <= decl_len_ff)
      else $error("received count passed declared length");

   a_hunt_count_clear: assert property (@(posedge clock) disable iff (reset)
      (byte_take && res_valid && res.kind != KIND_PAYLOAD) |=>
      (phase_ff == PH_SYNC0 && rcv_cnt_ff == 16'd0))
      else $error("frame end did not return to sync hunt");

endmodule

### rtl/sltd_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sltd_outq
// result register with skid stage between the parser and the rsp channel
// ----------------------------------------------------------------------------
module sltd_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sltd_pkg::result_type push_res,
   output logic                 full,
   output logic                 head_valid,
   output sltd_pkg::result_type head_res,
   input  logic                 pop
);
   import sltd_pkg::*;

   logic       head_valid_ff, head_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type head_ff, head_in;
   result_type skid_ff, skid_in;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_in       = push_res;
            skid_valid_in = push;
         end else begin
            head_in       = push_res;
            head_valid_in = push;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            skid_in       = push_res;
            skid_valid_in = 1'b1;
         end else begin
            head_in       = push_res;
            head_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign full       = skid_valid_ff;
   assign head_valid = head_valid_ff;
   assign head_res   = head_ff;

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry held without head entry");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && skid_valid_ff))
      else $error("transfer pushed into full queue");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid_ff)
      else $error("pop from empty queue");

endmodule
